// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and helper functions of the sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int MAX_RINGS   = 256;
   localparam int MAX_SECTORS = 256;
   localparam int TRIG_STAGES = 16;

   // long division: 41 bit dividend, 33 bit quotient, one quotient bit per stage
   localparam int NUM_W      = 41;
   localparam int QUO_W      = 33;
   localparam int DIV_STAGES = QUO_W;
   localparam int ANG_W      = 36;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // back pipeline: divider, fold, cordic, product, normal, position
   localparam int LAT     = DIV_STAGES + 1 + TRIG_STAGES + 3;
   localparam int TEX_LAT = LAT - DIV_STAGES;

   localparam logic [32:0] PI_Q30_U     = 33'd3373259426;
   localparam logic [32:0] TWO_PI_Q30_U = 33'd6746518852;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q30   = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] PI_Q30        = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30    = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] THR_HALF_PI   = 36'sd5059889139;
   localparam logic signed [ANG_W-1:0] GAIN_Q30      = 36'sd652032874;

   localparam logic [1:0] REG_RING   = 2'd0;
   localparam logic [1:0] REG_SECTOR = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef struct packed {
      logic [15:0] vertex_index;
      logic [15:0] upper_index;
      logic        quad_valid;
   } meta_type;

   typedef struct packed {
      logic [NUM_W-1:0] phi_num;
      logic [NUM_W-1:0] theta_num;
      logic [NUM_W-1:0] u_num;
      logic [NUM_W-1:0] v_num;
      meta_type         meta;
   } item_type;

   typedef struct packed {
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } tex_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
      logic signed [ANG_W-1:0] a;
      case (i)
         0:  a = 36'sh03243F6A8;
         1:  a = 36'sh01DAC6705;
         2:  a = 36'sh00FADBAFC;
         3:  a = 36'sh007F56EA6;
         4:  a = 36'sh003FEAB76;
         5:  a = 36'sh001FFD55B;
         6:  a = 36'sh000FFFAAA;
         7:  a = 36'sh0007FFF55;
         8:  a = 36'sh0003FFFEA;
         9:  a = 36'sh0001FFFFD;
         10: a = 36'sh0000FFFFF;
         11: a = 36'sh00007FFFF;
         12: a = 36'sh00003FFFF;
         13: a = 36'sh00001FFFF;
         14: a = 36'sh00000FFFF;
         15: a = 36'sh000007FFF;
         16: a = 36'sh000003FFF;
         17: a = 36'sh000001FFF;
         18: a = 36'sh000000FFF;
         19: a = 36'sh0000007FF;
         20: a = 36'sh0000003FF;
         21: a = 36'sh0000001FF;
         22: a = 36'sh0000000FF;
         23: a = 36'sh00000007F;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ANG_W-1:0] v);
      logic signed [15:0] o;
      if (v > 36'sd32767) o = 16'sh7FFF;
      else if (v < -36'sd32768) o = 16'sh8000;
      else o = v[15:0];
      return o;
   endfunction

endpackage

// ===== src/uvs_div.sv =====
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage, 8 bit divisor.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] dividend,
   input  logic [7:0]       divisor,
   output logic [QUO_W-1:0] quotient
);

   logic [7:0]       rem_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [7:0]       rem_src;
         logic [QUO_W-1:0] low_src;
         logic [QUO_W-1:0] quo_src;
         logic [8:0]       trial;
         logic             ge;
         logic [8:0]       diff;
         if (k == 0) begin : g_first
            // quotient fits 33 bits, so the top bits are already below the divisor
            assign rem_src = dividend[NUM_W-1:QUO_W];
            assign low_src = dividend[QUO_W-1:0];
            assign quo_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign low_src = low_ff[k-1];
            assign quo_src = quo_ff[k-1];
         end
         assign trial = {rem_src, low_src[QUO_W-1]};
         assign ge    = trial >= {1'b0, divisor};
         assign diff  = trial - {1'b0, divisor};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? diff[7:0] : trial[7:0];
               low_ff[k] <= {low_src[QUO_W-2:0], 1'b0};
               quo_ff[k] <= {quo_src[QUO_W-2:0], ge};
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

// ===== src/uvs_cordic.sv =====
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation-mode cordic in Q30, one stage per iteration.
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ANG_W-1:0] angle,
   output logic signed [ANG_W-1:0] cos_out,
   output logic signed [ANG_W-1:0] sin_out
);

   logic signed [ANG_W-1:0] x_ff [TRIG_STAGES];
   logic signed [ANG_W-1:0] y_ff [TRIG_STAGES];
   logic signed [ANG_W-1:0] z_ff [TRIG_STAGES];

   genvar i;
   generate
      for (i = 0; i < TRIG_STAGES; i++) begin : g_stage
         logic signed [ANG_W-1:0] sx, sy, sz, dx, dy;
         if (i == 0) begin : g_first
            assign sx = GAIN_Q30;
            assign sy = '0;
            assign sz = angle;
         end else begin : g_next
            assign sx = x_ff[i-1];
            assign sy = y_ff[i-1];
            assign sz = z_ff[i-1];
         end
         assign dx = sy >>> i;
         assign dy = sx >>> i;
         always_ff @(posedge clock) begin
            if (en) begin
               if (!sz[ANG_W-1]) begin
                  x_ff[i] <= sx - dx;
                  y_ff[i] <= sy + dy;
                  z_ff[i] <= sz - atan_q30(i);
               end else begin
                  x_ff[i] <= sx + dx;
                  y_ff[i] <= sy - dy;
                  z_ff[i] <= sz + atan_q30(i);
               end
            end
         end
      end
   endgenerate

   assign cos_out = x_ff[TRIG_STAGES-1];
   assign sin_out = y_ff[TRIG_STAGES-1];

endmodule

// ===== src/uvs_front.sv =====
// ----------------------------------------------------------------------------
// uvs_front
// Saturates the indices, forms dividends and indices, queues the request.
// ----------------------------------------------------------------------------
module uvs_front import uvs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] ring_index,
   input  logic [7:0] sector_index,
   input  logic [7:0] nr,
   input  logic [7:0] ns,
   input  logic [8:0] sectors,
   output logic       head_valid,
   output item_type   head,
   input  logic       pop
);

   item_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   logic [7:0]  r, s;
   logic [16:0] vidx, uidx;
   item_type    item;
   logic        push;

   always_comb begin
      r = (ring_index > nr) ? nr : ring_index;
      s = (sector_index > ns) ? ns : sector_index;
      item.phi_num   = NUM_W'(PI_Q30_U) * NUM_W'(r) + NUM_W'(nr >> 1);
      item.theta_num = NUM_W'(TWO_PI_Q30_U) * NUM_W'(s) + NUM_W'(ns >> 1);
      item.u_num     = NUM_W'({s, 16'd0}) + NUM_W'(ns >> 1);
      item.v_num     = NUM_W'({r, 16'd0}) + NUM_W'(nr >> 1);
      vidx = 17'(r) * 17'(sectors) + 17'(s);
      uidx = vidx + 17'(sectors);
      item.meta.quad_valid   = (r < nr) && (s < ns);
      item.meta.vertex_index = vidx[15:0];
      item.meta.upper_index  = item.meta.quad_valid ? uidx[15:0] : 16'd0;
   end

   assign in_ready   = count_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign push       = in_valid && in_ready;
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= item;
   end

endmodule

// ===== src/uvs_back.sv =====
// ----------------------------------------------------------------------------
// uvs_back
// Divides, runs both cordics and scales the normal by the radius.
// ----------------------------------------------------------------------------
module uvs_back import uvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  item_type           head,
   output logic               pop,
   input  logic [7:0]         nr,
   input  logic [7:0]         ns,
   input  logic [15:0]        radius,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] pos_x,
   output logic signed [31:0] pos_y,
   output logic signed [31:0] pos_z,
   output logic signed [15:0] norm_x,
   output logic signed [15:0] norm_y,
   output logic signed [15:0] norm_z,
   output tex_type            tex,
   output meta_type           meta
);

   logic en;
   logic vld_ff [LAT];
   meta_type meta_ff [LAT];
   tex_type  tex_ff [TEX_LAT];

   logic [QUO_W-1:0] phi_q, theta_q, u_q, v_q;

   // whole pipeline moves together, stalls only when the output is held
   assign en  = !vld_ff[LAT-1] || out_ready;
   assign pop = en && head_valid;

   uvs_div u_div_phi (.clock(clock), .en(en), .dividend(head.phi_num),
                      .divisor(nr), .quotient(phi_q));
   uvs_div u_div_theta (.clock(clock), .en(en), .dividend(head.theta_num),
                        .divisor(ns), .quotient(theta_q));
   uvs_div u_div_u (.clock(clock), .en(en), .dividend(head.u_num),
                    .divisor(ns), .quotient(u_q));
   uvs_div u_div_v (.clock(clock), .en(en), .dividend(head.v_num),
                    .divisor(nr), .quotient(v_q));

   genvar k;
   generate
      for (k = 0; k < LAT; k++) begin : g_line
         always_ff @(posedge clock) begin
            if (reset) vld_ff[k] <= 1'b0;
            else if (en) vld_ff[k] <= (k == 0) ? pop : vld_ff[(k == 0) ? 0 : k-1];
         end
         always_ff @(posedge clock) begin
            if (en) meta_ff[k] <= (k == 0) ? head.meta : meta_ff[(k == 0) ? 0 : k-1];
         end
      end
      for (k = 0; k < TEX_LAT; k++) begin : g_tex
         always_ff @(posedge clock) begin
            if (en) begin
               if (k == 0) begin
                  tex_ff[k].tex_u <= u_q[16:0];
                  tex_ff[k].tex_v <= v_q[16:0];
               end else begin
                  tex_ff[k] <= tex_ff[(k == 0) ? 0 : k-1];
               end
            end
         end
      end
   endgenerate

   // fold theta into the cordic range
   logic signed [ANG_W-1:0] zphi_ff, zth_ff, th;
   logic                    neg_ff;

   assign th = $signed({{(ANG_W-QUO_W){1'b0}}, theta_q});

   always_ff @(posedge clock) begin
      if (en) begin
         zphi_ff <= $signed({{(ANG_W-QUO_W){1'b0}}, phi_q}) - HALF_PI_Q30;
         if (th > THR_HALF_PI) begin
            zth_ff <= th - TWO_PI_Q30;
            neg_ff <= 1'b0;
         end else if (th > HALF_PI_Q30) begin
            zth_ff <= th - PI_Q30;
            neg_ff <= 1'b1;
         end else begin
            zth_ff <= th;
            neg_ff <= 1'b0;
         end
      end
   end

   logic signed [ANG_W-1:0] sin_phi, ncos_phi, cos_t, sin_t;
   logic neg_line_ff [TRIG_STAGES];

   uvs_cordic u_cordic_phi (.clock(clock), .en(en), .angle(zphi_ff),
                            .cos_out(sin_phi), .sin_out(ncos_phi));
   uvs_cordic u_cordic_theta (.clock(clock), .en(en), .angle(zth_ff),
                              .cos_out(cos_t), .sin_out(sin_t));

   generate
      for (k = 0; k < TRIG_STAGES; k++) begin : g_neg
         always_ff @(posedge clock) begin
            if (en) neg_line_ff[k] <= (k == 0) ? neg_ff : neg_line_ff[(k == 0) ? 0 : k-1];
         end
      end
   endgenerate

   // products of the angles
   logic signed [63:0] px, pz, px_ff, pz_ff;
   logic signed [15:0] ny_ff, ny2_ff, nx_ff, nz_ff;
   logic signed [ANG_W-1:0] ny_round;

   assign px       = $signed(cos_t[31:0]) * $signed(sin_phi[31:0]);
   assign pz       = $signed(sin_t[31:0]) * $signed(sin_phi[31:0]);
   assign ny_round = (ncos_phi + 36'sd16384) >>> 15;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= neg_line_ff[TRIG_STAGES-1] ? -px : px;
         pz_ff <= neg_line_ff[TRIG_STAGES-1] ? -pz : pz;
         ny_ff <= sat16(ny_round);
      end
   end

   logic signed [63:0] px_round, pz_round;
   assign px_round = (px_ff + 64'sh0000100000000000) >>> 45;
   assign pz_round = (pz_ff + 64'sh0000100000000000) >>> 45;

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff  <= sat16(px_round[ANG_W-1:0]);
         nz_ff  <= sat16(pz_round[ANG_W-1:0]);
         ny2_ff <= ny_ff;
      end
   end

   // position is normal times radius
   logic signed [16:0] rad_s;
   logic signed [32:0] mx, my, mz;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] onx_ff, ony_ff, onz_ff;

   assign rad_s = $signed({1'b0, radius});
   assign mx = nx_ff * rad_s;
   assign my = ny2_ff * rad_s;
   assign mz = nz_ff * rad_s;

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= mx[31:0];
         pos_y_ff <= my[31:0];
         pos_z_ff <= mz[31:0];
         onx_ff   <= nx_ff;
         ony_ff   <= ny2_ff;
         onz_ff   <= nz_ff;
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign pos_x  = pos_x_ff;
   assign pos_y  = pos_y_ff;
   assign pos_z  = pos_z_ff;
   assign norm_x = onx_ff;
   assign norm_y = ony_ff;
   assign norm_z = onz_ff;
   assign tex    = tex_ff[TEX_LAT-1];
   assign meta   = meta_ff[LAT-1];

endmodule

// ===== src/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// One vertex of a UV sphere per (ring, sector) request.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the output is held and returns one
// vertex per request, in order. After the four-entry input queue come 33
// stages of bit-per-stage long division for angles and texture coordinates,
// one fold stage, 16 cordic stages, and three stages of products, rounding
// and radius scaling. The whole back pipeline holds while an output vertex
// waits, the queue filling meanwhile. The user must write counts and radius
// over the register port only while no request is in flight (not enforced).
module uv_sphere_vertex_generator import uvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // ring_index[7:0], sector_index[15:8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
   // vertex_index, upper_index, zero fill
   output logic [215:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,   // quad_valid
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [8:0]  ring_ff, sector_ff;
   logic [15:0] radius_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff   <= 9'd16;
         sector_ff <= 9'd16;
         radius_ff <= 16'd256;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_RING:   ring_ff   <= csr_pwdata[8:0];
            REG_SECTOR: sector_ff <= csr_pwdata[8:0];
            REG_RADIUS: radius_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_RING:   csr_prdata = {23'd0, ring_ff};
         REG_SECTOR: csr_prdata = {23'd0, sector_ff};
         REG_RADIUS: csr_prdata = {16'd0, radius_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // counts clamp to 2 .. max
   logic [8:0] rings, sectors;
   logic [7:0] nr, ns;

   always_comb begin
      if (ring_ff < 9'd2) rings = 9'd2;
      else if (ring_ff > 9'(MAX_RINGS)) rings = 9'(MAX_RINGS);
      else rings = ring_ff;
      if (sector_ff < 9'd2) sectors = 9'd2;
      else if (sector_ff > 9'(MAX_SECTORS)) sectors = 9'(MAX_SECTORS);
      else sectors = sector_ff;
   end

   logic [8:0] nr_w, ns_w;
   assign nr_w = rings - 9'd1;
   assign ns_w = sectors - 9'd1;
   assign nr   = nr_w[7:0];
   assign ns   = ns_w[7:0];

   logic     head_valid, pop;
   item_type head;

   uvs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .ring_index(req_tdata[7:0]), .sector_index(req_tdata[15:8]),
      .nr(nr), .ns(ns), .sectors(sectors),
      .head_valid(head_valid), .head(head), .pop(pop)
   );

   logic signed [31:0] pos_x, pos_y, pos_z;
   logic signed [15:0] norm_x, norm_y, norm_z;
   tex_type  tex;
   meta_type meta;

   uvs_back u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head(head), .pop(pop),
      .nr(nr), .ns(ns), .radius(radius_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
      .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
      .tex(tex), .meta(meta)
   );

   assign rsp_tdata = {6'd0, meta.upper_index, meta.vertex_index, tex.tex_v, tex.tex_u,
                       norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
   assign rsp_tuser = meta.quad_valid;

endmodule

// ===== tb/uv_sphere_vertex_generator_tb.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_tb
// Self-checking bench for the sphere vertex generator: ring/sector requests
// go in through a randomly gapped driver, vertices are checked field by field
// against an in-bench fixed-point cordic model over several count/radius set-ups.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_tb;
   import uvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 120;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [16:0]        tex_u, tex_v;
      logic [15:0]        vertex_index, upper_index;
      logic               quad_valid;
   } vertex_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [215:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic [15:0] pending_reqs[$];
   vertex_t     expected_vertices[$];
   int          errors = 0;
   int          n_requests = 0;
   int          n_vertices = 0;
   int          n_setups = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          idle_cycles = 0;
   bit          no_idle = 0;

   // shadow of the register file
   int unsigned shadow_rings = 16;
   int unsigned shadow_sectors = 16;
   int unsigned shadow_radius = 256;

   longint atan_tab[16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF};

   uv_sphere_vertex_generator u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint sat_q15(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic rotate(input longint angle, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = angle;
      for (int i = 0; i < TRIG_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = x;
      s = y;
   endtask

   task automatic compute_vertex(input logic [7:0] ring_in, input logic [7:0] sector_in,
                                 output vertex_t v);
      longint unsigned rings, sectors, nr, ns, r, s;
      longint phi, theta, sgn, sin_phi, neg_cos_phi, cos_t, sin_t, nx, ny, nz, rad;
      longint prod;
      rings = shadow_rings < 2 ? 2 : (shadow_rings > MAX_RINGS ? MAX_RINGS : shadow_rings);
      sectors = shadow_sectors < 2 ? 2 :
                (shadow_sectors > MAX_SECTORS ? MAX_SECTORS : shadow_sectors);
      nr = rings - 1;
      ns = sectors - 1;
      r = ring_in > nr ? nr : ring_in;
      s = sector_in > ns ? ns : sector_in;
      rad = shadow_radius;
      sgn = 1;
      phi = (64'd3373259426 * r + nr / 2) / nr;
      theta = (64'd6746518852 * s + ns / 2) / ns;
      rotate(phi - 64'sd1686629713, sin_phi, neg_cos_phi);
      if (theta > 3 * 64'sd1686629713) begin
         theta -= 64'sd6746518852;
      end else if (theta > 64'sd1686629713) begin
         theta -= 64'sd3373259426;
         sgn = -1;
      end
      rotate(theta, cos_t, sin_t);
      cos_t *= sgn;
      sin_t *= sgn;
      nx = sat_q15((cos_t * sin_phi + (64'sd1 << 44)) >>> 45);
      ny = sat_q15((neg_cos_phi + (64'sd1 << 14)) >>> 15);
      nz = sat_q15((sin_t * sin_phi + (64'sd1 << 44)) >>> 45);
      prod = nx * rad; v.pos_x = prod[31:0];
      prod = ny * rad; v.pos_y = prod[31:0];
      prod = nz * rad; v.pos_z = prod[31:0];
      v.norm_x = nx[15:0];
      v.norm_y = ny[15:0];
      v.norm_z = nz[15:0];
      prod = (s * 65536 + ns / 2) / ns; v.tex_u = prod[16:0];
      prod = (r * 65536 + nr / 2) / nr; v.tex_v = prod[16:0];
      prod = r * sectors + s; v.vertex_index = prod[15:0];
      v.quad_valid = (r < nr) && (s < ns);
      prod = (r + 1) * sectors + s;
      v.upper_index = v.quad_valid ? prod[15:0] : 16'd0;
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      errors++;
      $display("mismatch on vertex %0d: %s got %0h expected %0h", n_vertices, field, got, want);
   endtask

   // request driver
   always @(posedge clock) begin
      vertex_t v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            compute_vertex(req_tdata[7:0], req_tdata[15:8], v);
            expected_vertices.push_back(v);
            n_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tdata <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_gap <= no_idle ? 0 : $urandom_range(0, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // vertex monitor
   always @(posedge clock) begin
      vertex_t w;
      int st;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0) begin
            errors++;
            $display("vertex %0d arrived with none expected", n_vertices);
         end else begin
            w = expected_vertices.pop_front();
            if ($signed(rsp_tdata[31:0]) != w.pos_x)
               report_mismatch("pos_x", rsp_tdata[31:0], w.pos_x);
            if ($signed(rsp_tdata[63:32]) != w.pos_y)
               report_mismatch("pos_y", rsp_tdata[63:32], w.pos_y);
            if ($signed(rsp_tdata[95:64]) != w.pos_z)
               report_mismatch("pos_z", rsp_tdata[95:64], w.pos_z);
            if (rsp_tdata[111:96] != w.norm_x)
               report_mismatch("norm_x", rsp_tdata[111:96], w.norm_x);
            if (rsp_tdata[127:112] != w.norm_y)
               report_mismatch("norm_y", rsp_tdata[127:112], w.norm_y);
            if (rsp_tdata[143:128] != w.norm_z)
               report_mismatch("norm_z", rsp_tdata[143:128], w.norm_z);
            if (rsp_tdata[160:144] != w.tex_u)
               report_mismatch("tex_u", rsp_tdata[160:144], w.tex_u);
            if (rsp_tdata[177:161] != w.tex_v)
               report_mismatch("tex_v", rsp_tdata[177:161], w.tex_v);
            if (rsp_tdata[193:178] != w.vertex_index)
               report_mismatch("vertex_index", rsp_tdata[193:178], w.vertex_index);
            if (rsp_tdata[209:194] != w.upper_index)
               report_mismatch("upper_index", rsp_tdata[209:194], w.upper_index);
            if (rsp_tdata[215:210] != '0)
               report_mismatch("fill", rsp_tdata[215:210], 0);
            if (rsp_tuser[0] != w.quad_valid)
               report_mismatch("quad_valid", rsp_tuser[0], w.quad_valid);
         end
         n_vertices++;
         st = no_idle ? 0 : $urandom_range(0, 13);
         rsp_stall <= st;
         rsp_tready <= (st == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_reqs.size() == 0 && expected_vertices.size() == 0 && !req_tvalid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("uv_sphere_vertex_generator_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr)
         4 * REG_RING:   shadow_rings = data & 32'h1FF;
         4 * REG_SECTOR: shadow_sectors = data & 32'h1FF;
         4 * REG_RADIUS: shadow_radius = data & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_vertices.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup(input int unsigned rings, input int unsigned sectors,
                        input int unsigned rad);
      csr_write(4'(4 * REG_RING), rings);
      csr_write(4'(4 * REG_SECTOR), sectors);
      csr_write(4'(4 * REG_RADIUS), rad);
      n_setups++;
   endtask

   task automatic random_burst(input int count);
      int unsigned lim_r, lim_s;
      logic [7:0] r, s;
      lim_r = shadow_rings < 2 ? 1 : (shadow_rings > 256 ? 255 : shadow_rings - 1);
      lim_s = shadow_sectors < 2 ? 1 : (shadow_sectors > 256 ? 255 : shadow_sectors - 1);
      for (int i = 0; i < count; i++) begin
         // mostly in-range indices, some saturating ones
         if ($urandom_range(0, 3) != 0) begin
            r = 8'($urandom_range(0, lim_r));
            s = 8'($urandom_range(0, lim_s));
         end else begin
            r = 8'($urandom);
            s = 8'($urandom);
         end
         pending_reqs.push_back({s, r});
      end
      // sender waits for every vertex before going on
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_vertices.size() == 0);
      for (int i = 0; i < count; i++)
         pending_reqs.push_back({8'($urandom), 8'($urandom)});
   endtask

   initial begin
      int unsigned rr, ss;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // reset values: 16 rings, 16 sectors, radius 256
      no_idle = 1;
      for (int i = 0; i < 6; i++)
         pending_reqs.push_back({8'(i * 3), 8'(15 - i)});
      pending_reqs.push_back({8'd15, 8'd15});
      pending_reqs.push_back({8'd255, 8'd255});
      pending_reqs.push_back({8'd14, 8'd14});
      pending_reqs.push_back({8'd4, 8'd8});
      pending_reqs.push_back({8'd12, 8'd0});
      drain();
      no_idle = 0;
      setup(2, 2, 65535);
      for (int i = 0; i < 4; i++)
         pending_reqs.push_back({8'(i[1] ? 255 : i[0]), 8'(i[0] ? 1 : 0)});
      drain();
      setup(256, 256, 1);
      pending_reqs.push_back({8'd0, 8'd0});
      pending_reqs.push_back({8'd64, 8'd128});
      pending_reqs.push_back({8'd255, 8'd255});
      pending_reqs.push_back({8'd254, 8'd127});
      pending_reqs.push_back({8'd192, 8'd191});
      drain();
      // counts below two and above the maximum clamp
      setup(0, 1, 0);
      pending_reqs.push_back({8'd1, 8'd1});
      pending_reqs.push_back({8'd0, 8'd0});
      drain();
      setup(511, 300, 32768);
      csr_write(4'd12, 32'h5);
      pending_reqs.push_back({8'd200, 8'd100});
      pending_reqs.push_back({8'd255, 8'd0});
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: setup(2, 256, 65535);
            1: setup(256, 2, 256);
            2: setup(16, 16, 256);
            default: begin
               rr = $urandom_range(2, 256);
               ss = $urandom_range(2, 256);
               setup(rr, ss, $urandom_range(0, 65535));
            end
         endcase
         no_idle = (ph == 5);
         random_burst(55);
         drain();
      end
      $display("covered %0d register set-ups, %0d requests, %0d vertices checked",
               n_setups, n_requests, n_vertices);
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("uv_sphere_vertex_generator_tb OK");
      end else begin
         $display("%0d mismatches, %0d vertices missing", errors, expected_vertices.size());
         $display("uv_sphere_vertex_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
